>>> rtl/core/tbb_pkg.sv
// Package for the tick bar builder with average true range.
// Holds window sizes, field widths, register indexes and reset values.
// No dependencies.
package tbb_pkg;

	localparam int ATR_WINDOW    = 14;
	localparam int VOLUME_WINDOW = 20;

	localparam int TIME_W   = 44;
	localparam int PRICE_W  = 23;
	localparam int TICKS_W  = 20;
	localparam int MEAN_W   = 28;
	localparam int COUNT_W  = 32;
	localparam int PERIOD_W = 27;
	localparam int CFG_IDX_W = 2;

	localparam int IN_W  = 72;
	localparam int OUT_W = 240;

	localparam int RF_W     = $clog2(ATR_WINDOW + 1);
	localparam int RSUM_W   = PRICE_W + $clog2(ATR_WINDOW);
	localparam int ATR_NUM_W = PRICE_W + $clog2(ATR_WINDOW) + 1;
	localparam int TF_W     = $clog2(VOLUME_WINDOW + 1);
	localparam int TWR_W    = (VOLUME_WINDOW > 1) ? $clog2(VOLUME_WINDOW) : 1;
	localparam int TSUM_W   = TICKS_W + $clog2(VOLUME_WINDOW);
	localparam int TDVD_W   = TSUM_W + 8;

	localparam int DIV_W   = TIME_W;
	localparam int CNT_W   = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_BAR_PERIOD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ATR_INITIAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ATR_FLOOR   = 2'd2;

	localparam logic [PERIOD_W-1:0] PERIOD_RST      = 27'd900000;
	localparam logic [PRICE_W-1:0]  ATR_INITIAL_RST = 23'd5000;
	localparam logic [PRICE_W-1:0]  ATR_FLOOR_RST   = 23'd500;
	localparam logic [MEAN_W-1:0]   TICK_MEAN_RST   = 28'd25600;
	localparam logic [TICKS_W-1:0]  TICK_MAX        = '1;

endpackage

>>> rtl/core/tick_bar_builder_with_atr_unit.sv
// Top level of the tick bar builder: OHLC bars, ATR and tick-volume mean.
// Depends on tbb_pkg. The bar-volume ring is a synchronous memory here.
//
// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tick time, mid price
// m_axis    out        m_axis_tvalid/tready       closed bar and indicators, tuser flag
// cfg       in         cfg_valid/cfg_ready        register index, write data
//
// A tick that stays inside a bar whose boundary is known goes from acceptance through the compare and emit states.
// The next tick after a bar opens or after a period write also runs the shared
// restoring divider for the boundary (44 steps) before the compare.
// A closing tick also runs the ATR and tick-mean divisions; the first close skips them.
// Reset is asynchronous; no clearing pass is needed since the ring is read only where written.
// A new request is taken while the previous result waits in the output register.
module tick_bar_builder_with_atr_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [tbb_pkg::IN_W-1:0]           s_axis_tdata,  // tick_time_ms, mid_price
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// bar_start_ms, bar_open, bar_high, bar_low, bar_last, bar_tick_total,
	// atr_value, tick_volume_mean, bars_closed_count
	output logic [tbb_pkg::OUT_W-1:0]          m_axis_tdata,
	output logic                               m_axis_tuser,  // bar_closed
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tbb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tbb_pkg::PERIOD_W-1:0]       cfg_data
);

	typedef enum logic [3:0] {
		IDLE, BND_DIV, BND_BASE, BND_ADD, CMP, TR,
		ATR_A, ATR_B, ATR_DIV, ATR_FIN, TCK_A, TCK_B, TCK_DIV, TCK_FIN, EMIT
	} st_t;

	st_t state_q;

	logic [tbb_pkg::PERIOD_W-1:0] period_q;
	logic [tbb_pkg::PRICE_W-1:0]  atr_floor_q;

	logic [tbb_pkg::TIME_W-1:0]  tick_t_q;
	logic [tbb_pkg::PRICE_W-1:0] tick_p_q;

	logic                         running_q;
	logic [tbb_pkg::TIME_W-1:0]  cur_start_q;
	logic [tbb_pkg::PRICE_W-1:0] cur_open_q, cur_high_q, cur_low_q, cur_last_q;
	logic [tbb_pkg::TICKS_W-1:0] cur_ticks_q;
	logic [tbb_pkg::PRICE_W-1:0] prev_last_q;
	logic [tbb_pkg::COUNT_W-1:0] count_q;
	logic                         bnd_valid_q;
	logic [tbb_pkg::TIME_W:0]    bnd_q;

	logic [tbb_pkg::RF_W-1:0]      rng_fill_q;
	logic [tbb_pkg::RSUM_W-1:0]    rsum_q;
	logic [tbb_pkg::ATR_NUM_W-1:0] mul_q;
	logic [tbb_pkg::PRICE_W-1:0]   tr_q;
	logic [tbb_pkg::PRICE_W-1:0]   atr_q;
	logic [tbb_pkg::MEAN_W-1:0]    mean_q;

	logic [tbb_pkg::TF_W-1:0]    tck_fill_q;
	logic [tbb_pkg::TWR_W-1:0]   tck_wr_q;
	logic [tbb_pkg::TSUM_W-1:0]  tsum_q;
	logic [tbb_pkg::TICKS_W-1:0] tck_mem [tbb_pkg::VOLUME_WINDOW];
	logic [tbb_pkg::TICKS_W-1:0] tck_rd_q;

	logic                         res_closed_q;
	logic [tbb_pkg::TIME_W-1:0]  res_start_q;
	logic [tbb_pkg::PRICE_W-1:0] res_open_q, res_high_q, res_low_q, res_last_q;
	logic [tbb_pkg::TICKS_W-1:0] res_ticks_q;
	logic [tbb_pkg::PRICE_W-1:0] res_atr_q;
	logic [tbb_pkg::MEAN_W-1:0]  res_mean_q;

	logic [tbb_pkg::OUT_W-1:0] out_data_q;
	logic                      out_user_q;
	logic                      out_valid_q;

	logic [tbb_pkg::DIV_W-1:0]    dvd_q;
	logic [tbb_pkg::PERIOD_W-1:0] rem_q;
	logic [tbb_pkg::PERIOD_W-1:0] dvs_q;
	logic [tbb_pkg::CNT_W-1:0]    cnt_q;

	logic [tbb_pkg::PERIOD_W-1:0] eff_period;
	logic [tbb_pkg::PERIOD_W:0]   trial;
	logic [tbb_pkg::PERIOD_W+1:0] diff;
	logic                         borrow;
	logic                         div_step;
	logic                         in_acc;
	logic                         out_free;
	logic [tbb_pkg::COUNT_W-1:0]  count_nx;
	logic                         atr_full;
	logic [tbb_pkg::ATR_NUM_W-1:0] atr_num;
	logic [tbb_pkg::TDVD_W-1:0]   tck_num;
	logic [tbb_pkg::PRICE_W-1:0]  atr_quo;
	logic [tbb_pkg::PRICE_W-1:0]  tr_hi, tr_lo;
	logic [tbb_pkg::TICKS_W-1:0]  tck_evict;
	logic [tbb_pkg::OUT_W-1:0]    res_packed;

	assign eff_period = (period_q == '0) ? tbb_pkg::PERIOD_W'(1) : period_q;
	assign trial      = {rem_q, dvd_q[tbb_pkg::DIV_W-1]};
	assign diff       = {1'b0, trial} - {2'b00, dvs_q};
	assign borrow     = diff[tbb_pkg::PERIOD_W+1];
	assign div_step   = (state_q == BND_DIV) || (state_q == ATR_DIV) || (state_q == TCK_DIV);

	assign s_axis_tready = (state_q == IDLE);
	assign cfg_ready     = (state_q == IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign count_nx      = count_q + tbb_pkg::COUNT_W'(1);

	assign atr_full = (rng_fill_q == tbb_pkg::RF_W'(tbb_pkg::ATR_WINDOW));
	assign atr_num  = atr_full
		? mul_q + tbb_pkg::ATR_NUM_W'(tr_q) + tbb_pkg::ATR_NUM_W'(tbb_pkg::ATR_WINDOW / 2)
		: tbb_pkg::ATR_NUM_W'(rsum_q) + tbb_pkg::ATR_NUM_W'(rng_fill_q >> 1);
	assign tck_num  = {tsum_q, 8'h00} + tbb_pkg::TDVD_W'(tck_fill_q >> 1);
	assign atr_quo  = dvd_q[tbb_pkg::PRICE_W-1:0];

	assign tr_hi = (prev_last_q > res_high_q) ? prev_last_q : res_high_q;
	assign tr_lo = (prev_last_q < res_low_q) ? prev_last_q : res_low_q;
	assign tck_evict = (tck_fill_q == tbb_pkg::TF_W'(tbb_pkg::VOLUME_WINDOW)) ? tck_rd_q : '0;

	assign res_packed = res_closed_q
		? {1'b0, count_q, res_mean_q, res_atr_q, res_ticks_q,
		   res_last_q, res_low_q, res_high_q, res_open_q, res_start_q}
		: '0;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	always_ff @(posedge clk) begin
		if (state_q == TCK_A) begin
			tck_mem[tck_wr_q] <= res_ticks_q;
		end
		tck_rd_q <= tck_mem[tck_wr_q];
	end

	always_ff @(posedge clk) begin
		if (div_step) begin
			rem_q <= borrow ? trial[tbb_pkg::PERIOD_W-1:0] : diff[tbb_pkg::PERIOD_W-1:0];
			dvd_q <= {dvd_q[tbb_pkg::DIV_W-2:0], !borrow};
			cnt_q <= cnt_q - tbb_pkg::CNT_W'(1);
		end else if (state_q == IDLE) begin
			rem_q <= '0;
			dvs_q <= eff_period;
			dvd_q <= cur_start_q;
			cnt_q <= tbb_pkg::CNT_W'(tbb_pkg::TIME_W - 1);
		end else if (state_q == ATR_B) begin
			rem_q <= '0;
			dvs_q <= atr_full ? tbb_pkg::PERIOD_W'(tbb_pkg::ATR_WINDOW)
			                  : tbb_pkg::PERIOD_W'(rng_fill_q);
			dvd_q <= tbb_pkg::DIV_W'(atr_num) << (tbb_pkg::DIV_W - tbb_pkg::ATR_NUM_W);
			cnt_q <= tbb_pkg::CNT_W'(tbb_pkg::ATR_NUM_W - 1);
		end else if (state_q == TCK_B) begin
			rem_q <= '0;
			dvs_q <= tbb_pkg::PERIOD_W'(tck_fill_q);
			dvd_q <= tbb_pkg::DIV_W'(tck_num) << (tbb_pkg::DIV_W - tbb_pkg::TDVD_W);
			cnt_q <= tbb_pkg::CNT_W'(tbb_pkg::TDVD_W - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			period_q     <= tbb_pkg::PERIOD_RST;
			atr_floor_q  <= tbb_pkg::ATR_FLOOR_RST;
			running_q    <= 1'b0;
			cur_start_q  <= '0;
			cur_open_q   <= '0;
			cur_high_q   <= '0;
			cur_low_q    <= '0;
			cur_last_q   <= '0;
			cur_ticks_q  <= '0;
			prev_last_q  <= '0;
			count_q      <= '0;
			bnd_valid_q  <= 1'b0;
			rng_fill_q   <= '0;
			rsum_q       <= '0;
			atr_q        <= tbb_pkg::ATR_INITIAL_RST;
			mean_q       <= tbb_pkg::TICK_MEAN_RST;
			tck_fill_q   <= '0;
			tck_wr_q     <= '0;
			tsum_q       <= '0;
			res_closed_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready && (state_q != EMIT)) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					tbb_pkg::CFG_BAR_PERIOD: begin
						period_q    <= cfg_data;
						bnd_valid_q <= 1'b0;
					end
					tbb_pkg::CFG_ATR_INITIAL: begin
						if (rng_fill_q == '0) begin
							atr_q <= cfg_data[tbb_pkg::PRICE_W-1:0];
						end
					end
					tbb_pkg::CFG_ATR_FLOOR: begin
						atr_floor_q <= cfg_data[tbb_pkg::PRICE_W-1:0];
					end
					default: begin
					end
				endcase
			end
			unique case (state_q)
				IDLE: begin
					if (in_acc) begin
						tick_t_q <= s_axis_tdata[tbb_pkg::TIME_W-1:0];
						tick_p_q <= s_axis_tdata[tbb_pkg::TIME_W +: tbb_pkg::PRICE_W];
						if (!running_q) begin
							running_q    <= 1'b1;
							res_closed_q <= 1'b0;
							cur_start_q  <= s_axis_tdata[tbb_pkg::TIME_W-1:0];
							cur_open_q   <= s_axis_tdata[tbb_pkg::TIME_W +: tbb_pkg::PRICE_W];
							cur_high_q   <= s_axis_tdata[tbb_pkg::TIME_W +: tbb_pkg::PRICE_W];
							cur_low_q    <= s_axis_tdata[tbb_pkg::TIME_W +: tbb_pkg::PRICE_W];
							cur_last_q   <= s_axis_tdata[tbb_pkg::TIME_W +: tbb_pkg::PRICE_W];
							cur_ticks_q  <= tbb_pkg::TICKS_W'(1);
							state_q      <= EMIT;
						end else if (bnd_valid_q) begin
							state_q <= CMP;
						end else begin
							state_q <= BND_DIV;
						end
					end
				end
				BND_DIV: begin
					if (cnt_q == '0) begin
						state_q <= BND_BASE;
					end
				end
				BND_BASE: begin
					bnd_q   <= {1'b0, cur_start_q} - (tbb_pkg::TIME_W + 1)'(rem_q);
					state_q <= BND_ADD;
				end
				BND_ADD: begin
					bnd_q       <= bnd_q + (tbb_pkg::TIME_W + 1)'(eff_period);
					bnd_valid_q <= 1'b1;
					state_q     <= CMP;
				end
				CMP: begin
					if ({1'b0, tick_t_q} >= bnd_q) begin
						count_q      <= count_nx;
						res_closed_q <= 1'b1;
						res_start_q  <= cur_start_q;
						res_open_q   <= cur_open_q;
						res_high_q   <= cur_high_q;
						res_low_q    <= cur_low_q;
						res_last_q   <= cur_last_q;
						res_ticks_q  <= cur_ticks_q;
						bnd_valid_q  <= 1'b0;
						cur_start_q  <= tick_t_q;
						cur_open_q   <= tick_p_q;
						cur_high_q   <= tick_p_q;
						cur_low_q    <= tick_p_q;
						cur_last_q   <= tick_p_q;
						cur_ticks_q  <= tbb_pkg::TICKS_W'(1);
						state_q      <= TR;
					end else begin
						res_closed_q <= 1'b0;
						if (tick_p_q > cur_high_q) begin
							cur_high_q <= tick_p_q;
						end
						if (tick_p_q < cur_low_q) begin
							cur_low_q <= tick_p_q;
						end
						cur_last_q <= tick_p_q;
						if (cur_ticks_q != tbb_pkg::TICK_MAX) begin
							cur_ticks_q <= cur_ticks_q + tbb_pkg::TICKS_W'(1);
						end
						state_q <= EMIT;
					end
				end
				TR: begin
					tr_q        <= tr_hi - tr_lo;
					prev_last_q <= res_last_q;
					res_atr_q   <= atr_q;
					res_mean_q  <= mean_q;
					state_q     <= (count_q == tbb_pkg::COUNT_W'(1)) ? EMIT : ATR_A;
				end
				ATR_A: begin
					if (!atr_full) begin
						rsum_q     <= rsum_q + tbb_pkg::RSUM_W'(tr_q);
						rng_fill_q <= rng_fill_q + tbb_pkg::RF_W'(1);
					end
					mul_q   <= tbb_pkg::ATR_NUM_W'(atr_q) *
					           tbb_pkg::ATR_NUM_W'(tbb_pkg::ATR_WINDOW - 1);
					state_q <= ATR_B;
				end
				ATR_B: begin
					state_q <= ATR_DIV;
				end
				ATR_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ATR_FIN;
					end
				end
				ATR_FIN: begin
					atr_q     <= (atr_quo < atr_floor_q) ? atr_floor_q : atr_quo;
					res_atr_q <= (atr_quo < atr_floor_q) ? atr_floor_q : atr_quo;
					state_q   <= TCK_A;
				end
				TCK_A: begin
					tsum_q <= tsum_q - tbb_pkg::TSUM_W'(tck_evict) +
					          tbb_pkg::TSUM_W'(res_ticks_q);
					if (tck_wr_q == tbb_pkg::TWR_W'(tbb_pkg::VOLUME_WINDOW - 1)) begin
						tck_wr_q <= '0;
					end else begin
						tck_wr_q <= tck_wr_q + tbb_pkg::TWR_W'(1);
					end
					if (tck_fill_q != tbb_pkg::TF_W'(tbb_pkg::VOLUME_WINDOW)) begin
						tck_fill_q <= tck_fill_q + tbb_pkg::TF_W'(1);
					end
					state_q <= TCK_B;
				end
				TCK_B: begin
					state_q <= TCK_DIV;
				end
				TCK_DIV: begin
					if (cnt_q == '0) begin
						state_q <= TCK_FIN;
					end
				end
				TCK_FIN: begin
					mean_q     <= dvd_q[tbb_pkg::MEAN_W-1:0];
					res_mean_q <= dvd_q[tbb_pkg::MEAN_W-1:0];
					state_q    <= EMIT;
				end
				EMIT: begin
					if (out_free) begin
						out_data_q  <= res_packed;
						out_user_q  <= res_closed_q;
						out_valid_q <= 1'b1;
						state_q     <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule
